@@ hw/rtl/sorted_insert_list_buffer_assert.svh @@
// assertion macros used by the sorted list buffer rtl
`ifndef SORTED_INSERT_LIST_BUFFER_ASSERT_SVH
`define SORTED_INSERT_LIST_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while rst_n is low
`define SIL_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted list buffer assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SIL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted list buffer assertion failed");

`else

`define SIL_ASSERT_IMPLY(lbl, ante, cons)
`define SIL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/sil_pkg.sv @@
// types and constants of the sorted list buffer
package sil_pkg;

  localparam int DEPTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                   mode;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] item_value;
    logic                    last_item;
    status_t                 status;
  } out_beat_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                op;
    logic                    append;
    logic signed [VAL_W-1:0] wr_value;
  } cell_ctl_t;

endpackage

@@ hw/rtl/sil_cell.sv @@
// one storage cell of the list chain: compare, shift in, rotate out
module sil_cell (
  input  logic                           clk,
  input  sil_pkg::cell_ctl_t             ctl,
  input  logic                           occupied,
  input  logic                           is_tail,
  input  logic                           prefix_in,
  input  logic signed [sil_pkg::VAL_W-1:0] left_value,
  input  logic signed [sil_pkg::VAL_W-1:0] right_value,
  input  logic signed [sil_pkg::VAL_W-1:0] head_value,
  output logic                           prefix_out,
  output logic signed [sil_pkg::VAL_W-1:0] value_out
);
  import sil_pkg::*;

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;
  logic                    lt;

  // entry stays ahead of the new value (append keeps every stored entry ahead)
  assign lt         = occupied & (ctl.append | ($signed(value_r) < $signed(ctl.wr_value)));
  assign prefix_out = prefix_in & lt;
  assign value_out  = value_r;

  // next entry: shift from the left past the insert point, rotate toward head on read
  always_comb begin
    value_nxt = value_r;
    unique case (ctl.op)
      CELL_WRITE: begin
        if (!prefix_in) begin
          value_nxt = left_value;
        end else if (!lt) begin
          value_nxt = ctl.wr_value;
        end
      end
      CELL_ROTATE: begin
        value_nxt = is_tail ? head_value : right_value;
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

@@ hw/rtl/sorted_insert_list_buffer.sv @@
// sorted list buffer: top level with control and the chain of cells
// clear, append and insert: one result beat the cycle after start, busy stays low
// readout of n entries: start sets busy, then n beats on back-to-back cycles, each the registered head cell value,
//   busy high until the last beat shows and low again with it; head cell is the read port
// readout of an empty list: one beat the cycle after start
// reset (rst_n low, synchronous): list empty, stored values undefined, no beat pending
`include "sorted_insert_list_buffer_assert.svh"

module sorted_insert_list_buffer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sil_pkg::in_beat_t   in_data,
  output logic                busy,
  output logic                out_valid,
  output sil_pkg::out_beat_t  out_data
);
  import sil_pkg::*;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        rd_left_r, rd_left_nxt;
  logic                    busy_r, busy_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_data_r, out_data_nxt;
  logic                    accept;
  logic                    full;
  logic                    is_write;
  cell_ctl_t               ctl;
  logic signed [VAL_W-1:0] cell_val [DEPTH];
  logic                    prefix [DEPTH+1];

  assign accept   = start & ~busy_r;
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign is_write = (in_data.mode == MODE_APPEND) || (in_data.mode == MODE_INSERT);

  // command to the chain
  always_comb begin
    ctl.append   = (in_data.mode == MODE_APPEND);
    ctl.wr_value = in_data.value;
    if (busy_r) begin
      ctl.op = CELL_ROTATE;
    end else if (accept && is_write && !full) begin
      ctl.op = CELL_WRITE;
    end else begin
      ctl.op = CELL_HOLD;
    end
  end

  // chain of cells, insert point found by the prefix carried left to right
  assign prefix[0] = 1'b1;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [VAL_W-1:0] left_v;
      logic signed [VAL_W-1:0] right_v;
      if (gi == 0) begin : g_first
        assign left_v = '0;
      end else begin : g_mid_l
        assign left_v = cell_val[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_mid_r
        assign right_v = cell_val[gi+1];
      end
      sil_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occupied    (CNT_W'(gi) < cnt_r),
        .is_tail     (CNT_W'(gi + 1) == cnt_r),
        .prefix_in   (prefix[gi]),
        .left_value  (left_v),
        .right_value (right_v),
        .head_value  (cell_val[0]),
        .prefix_out  (prefix[gi+1]),
        .value_out   (cell_val[gi])
      );
    end
  endgenerate

  // control: entry count, readout sequencing and the result beat
  always_comb begin
    cnt_nxt       = cnt_r;
    rd_left_nxt   = rd_left_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    if (busy_r) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.item_value = cell_val[0];
      out_data_nxt.last_item  = (rd_left_r == CNT_W'(1));
      out_data_nxt.status     = ST_OK;
      rd_left_nxt             = rd_left_r - CNT_W'(1);
      busy_nxt                = (rd_left_r != CNT_W'(1));
    end else if (accept) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.item_value = '0;
      out_data_nxt.last_item  = 1'b1;
      out_data_nxt.status     = ST_OK;
      unique case (in_data.mode)
        MODE_CLEAR: begin
          cnt_nxt = '0;
        end
        MODE_APPEND, MODE_INSERT: begin
          if (full) begin
            out_data_nxt.status = ST_FULL;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        MODE_READ: begin
          if (cnt_r == '0) begin
            out_data_nxt.status = ST_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            busy_nxt      = 1'b1;
            rd_left_nxt   = cnt_r;
          end
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_left_r   <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rd_left_r   <= rd_left_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `SIL_ASSERT_NEXT(a_write_beat, accept && (in_data.mode != MODE_READ), out_valid_r)
  `SIL_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `SIL_ASSERT_IMPLY(a_busy_left, busy_r, (rd_left_r != '0) && (rd_left_r <= cnt_r))
  `SIL_ASSERT_NEXT(a_clear_empty, accept && (in_data.mode == MODE_CLEAR), cnt_r == '0)
  `SIL_ASSERT_NEXT(a_read_beat, busy_r, out_valid_r)

endmodule
